// ----- hw/rtl/wrms_pkg.sv -----
// ----------------------------------------------------------------------------
// wrms_pkg
// Types and constants shared by the weighted running mean/stddev block.
// ----------------------------------------------------------------------------
`default_nettype none

package wrms_pkg;

    localparam int FRAC_BITS = 16;

    typedef struct packed {
        logic               has_record;
        logic signed [31:0] price;
        logic [30:0]        quantity;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [31:0]        total_count;
        logic signed [31:0] mean_rounded;
        logic [31:0]        stddev_rounded;
        logic               overflow;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_DIV,
        S_SQRT,
        S_POST,
        S_OUT
    } t_state;

    // which point of the sequence a finished unit operation returns to
    typedef enum logic [2:0] {
        ST_MD,
        ST_MDD,
        ST_DD,
        ST_TW,
        ST_END,
        ST_VAR,
        ST_SQ
    } t_step;

endpackage

`default_nettype wire

// ----- hw/rtl/wrms_if.sv -----
// ----------------------------------------------------------------------------
// wrms_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface wrms_in_if;
    import wrms_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface wrms_out_if;
    import wrms_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/weighted_running_mean_stddev_top.sv -----
// sequence: a record runs a 64-step multiply, an 80-step divide and up to two
//   more 64-step multiplies; a last item of a run with a count above one adds a
//   64-step divide and a 32-step root before the result beat
// throughput: one item at a time, set by the shared shift-add/subtract unit
// reset: synchronous active-low, clears count, mean, deviation sum and flag
// ----------------------------------------------------------------------------
// weighted_running_mean_stddev_top
// Weighted running mean and sample stddev over a run of price/quantity records.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_running_mean_stddev_top
    import wrms_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    wrms_in_if.sink    i_in,
    wrms_out_if.source o_out
);

    localparam logic [63:0] ALL_ONES = '1;

    t_state             r_state, n_state;
    t_step              r_step, n_step;
    logic [6:0]         r_k, n_k;
    t_in_item           r_item, n_item;
    logic [31:0]        r_cnt, n_cnt;
    logic signed [63:0] r_mean, n_mean;
    logic [63:0]        r_ssd, n_ssd;
    logic               r_sat, n_sat;
    logic [31:0]        r_w, n_w;
    logic [63:0]        r_d1, n_d1;
    logic               r_neg, n_neg;
    logic [127:0]       r_mcand, n_mcand;
    logic [63:0]        r_mplier, n_mplier;
    logic [127:0]       r_acc, n_acc;
    logic [63:0]        r_quo, n_quo;
    logic [31:0]        r_rem, n_rem;
    logic [31:0]        r_dvs, n_dvs;
    logic [31:0]        r_root, n_root;
    logic [35:0]        r_srem, n_srem;
    t_out_item          r_out, n_out;

    logic signed [63:0] xf;
    logic signed [63:0] dif;
    logic signed [63:0] m_new;
    logic signed [63:0] d2s;
    logic [32:0]        csum;
    logic [32:0]        dtrial;
    logic               dge;
    logic [35:0]        st, strial;
    logic               sge;
    logic [127:0]       sh;
    logic [63:0]        term;
    logic [64:0]        ssum;
    logic [63:0]        mabs;
    logic [63:0]        mrnd;
    logic [32:0]        sd33;

    assign xf = {{(32 - FRAC_BITS){r_item.price[31]}}, r_item.price, {FRAC_BITS{1'b0}}};
    assign dif = xf - r_mean;
    assign csum = {1'b0, r_cnt} + {2'b0, r_item.quantity};
    assign dtrial = {r_rem, r_acc[127]};
    assign dge = dtrial >= {1'b0, r_dvs};
    assign st = {r_srem[33:0], r_acc[127:126]};
    assign strial = {2'b0, r_root, 2'b01};
    assign sge = st >= strial;
    assign m_new = r_neg ? r_mean - $signed(r_quo) : r_mean + $signed(r_quo);
    assign d2s = xf - m_new;
    assign sh = r_acc >> FRAC_BITS;
    assign term = (r_acc[127:64] != 64'd0) ? ALL_ONES : r_acc[63:0];
    assign ssum = {1'b0, r_ssd} + {1'b0, term};
    assign mabs = r_mean[63] ? 64'd0 - r_mean : r_mean;
    assign mrnd = (mabs + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign sd33 = ({1'b0, r_root} + 33'd1) >> 1;

    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = (r_state == S_OUT);
    assign o_out.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= ST_END;
            r_cnt   <= '0;
            r_mean  <= '0;
            r_ssd   <= '0;
            r_sat   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_cnt   <= n_cnt;
            r_mean  <= n_mean;
            r_ssd   <= n_ssd;
            r_sat   <= n_sat;
        end
        r_k      <= n_k;
        r_item   <= n_item;
        r_w      <= n_w;
        r_d1     <= n_d1;
        r_neg    <= n_neg;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_acc    <= n_acc;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_dvs    <= n_dvs;
        r_root   <= n_root;
        r_srem   <= n_srem;
        r_out    <= n_out;
    end

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_k      = r_k;
        n_item   = r_item;
        n_cnt    = r_cnt;
        n_mean   = r_mean;
        n_ssd    = r_ssd;
        n_sat    = r_sat;
        n_w      = r_w;
        n_d1     = r_d1;
        n_neg    = r_neg;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_acc    = r_acc;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_dvs    = r_dvs;
        n_root   = r_root;
        n_srem   = r_srem;
        n_out    = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_item  = i_in.payload;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_step  = ST_END;
                n_state = S_POST;
                if (r_item.has_record && r_item.quantity != 31'd0) begin
                    if (r_cnt == 32'd0) begin
                        n_cnt  = {1'b0, r_item.quantity};
                        n_mean = xf;
                        n_ssd  = '0;
                    end else begin
                        if (csum[32]) begin
                            n_sat = 1'b1;
                            n_w   = ~r_cnt;
                        end else begin
                            n_w   = {1'b0, r_item.quantity};
                        end
                        if (!(csum[32] && r_cnt == '1)) begin
                            n_cnt    = csum[32] ? '1 : csum[31:0];
                            n_neg    = dif[63];
                            n_d1     = dif[63] ? 64'd0 - dif : dif;
                            n_mcand  = {64'd0, n_d1};
                            n_mplier = {32'd0, n_w};
                            n_acc    = '0;
                            n_k      = 7'd64;
                            n_step   = ST_MD;
                            n_state  = S_MUL;
                        end
                    end
                end
            end
            S_MUL: begin
                if (r_mplier[0]) n_acc = r_acc + r_mcand;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_k      = r_k - 7'd1;
                if (r_k == 7'd1) n_state = S_POST;
            end
            S_DIV: begin
                n_rem   = dge ? 32'(dtrial - {1'b0, r_dvs}) : dtrial[31:0];
                n_quo   = {r_quo[62:0], dge};
                n_acc   = r_acc << 1;
                n_k     = r_k - 7'd1;
                if (r_k == 7'd1) n_state = S_POST;
            end
            S_SQRT: begin
                n_srem  = sge ? st - strial : st;
                n_root  = {r_root[30:0], sge};
                n_acc   = r_acc << 2;
                n_k     = r_k - 7'd1;
                if (r_k == 7'd1) n_state = S_POST;
            end
            S_POST: begin
                unique case (r_step)
                    ST_MD: begin
                        // product is below 2^(64 + FRAC_BITS): align its top to the msb
                        n_acc   = r_acc << (64 - FRAC_BITS);
                        n_dvs   = r_cnt;
                        n_rem   = '0;
                        n_quo   = '0;
                        n_k     = 7'(64 + FRAC_BITS);
                        n_step  = ST_MDD;
                        n_state = S_DIV;
                    end
                    ST_MDD: begin
                        n_mean   = m_new;
                        n_mcand  = {64'd0, r_d1};
                        n_mplier = d2s[63] ? 64'd0 - d2s : d2s;
                        n_acc    = '0;
                        n_k      = 7'd64;
                        n_step   = ST_DD;
                        n_state  = S_MUL;
                    end
                    ST_DD: begin
                        if (sh[127:64] != 64'd0) begin
                            n_acc   = {64'd1, 64'd0};
                            n_state = S_POST;
                            n_step  = ST_TW;
                        end else begin
                            n_mcand  = {64'd0, sh[63:0]};
                            n_mplier = {32'd0, r_w};
                            n_acc    = '0;
                            n_k      = 7'd64;
                            n_step   = ST_TW;
                            n_state  = S_MUL;
                        end
                    end
                    ST_TW: begin
                        if (r_acc[127:64] != 64'd0 || ssum[64]) n_sat = 1'b1;
                        n_ssd  = ssum[64] ? ALL_ONES : ssum[63:0];
                        n_step = ST_END;
                    end
                    ST_END: begin
                        if (!r_item.last) begin
                            n_state = S_IDLE;
                        end else begin
                            n_out.total_count  = r_cnt;
                            n_out.overflow     = r_sat;
                            n_out.mean_rounded = (r_cnt == 32'd0) ? 32'sd0 :
                                r_mean[63] ? 32'(64'd0 - mrnd) : mrnd[31:0];
                            n_out.stddev_rounded = '0;
                            if (r_cnt > 32'd1) begin
                                n_acc   = {r_ssd, 64'd0};
                                n_dvs   = r_cnt - 32'd1;
                                n_rem   = '0;
                                n_quo   = '0;
                                n_k     = 7'd64;
                                n_step  = ST_VAR;
                                n_state = S_DIV;
                            end else begin
                                n_cnt   = '0;
                                n_mean  = '0;
                                n_ssd   = '0;
                                n_sat   = 1'b0;
                                n_state = S_OUT;
                            end
                        end
                    end
                    ST_VAR: begin
                        n_acc   = {r_quo >> (FRAC_BITS - 2), 64'd0};
                        n_srem  = '0;
                        n_root  = '0;
                        n_k     = 7'd32;
                        n_step  = ST_SQ;
                        n_state = S_SQRT;
                    end
                    ST_SQ: begin
                        n_out.stddev_rounded = sd33[31:0];
                        n_cnt   = '0;
                        n_mean  = '0;
                        n_ssd   = '0;
                        n_sat   = 1'b0;
                        n_state = S_OUT;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_OUT: begin
                if (o_out.ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // a result beat and an input beat never overlap
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while result pending");

    // state is already cleared while a result waits
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_cnt == 32'd0 && r_ssd == 64'd0 && !r_sat))
        else $error("state not cleared at result");

    // an empty run has no deviation sum
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_cnt == 32'd0) |-> (r_ssd == 64'd0))
        else $error("deviation sum without records");

    // an accepted beat always starts the sequencer
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_PREP))
        else $error("accepted beat not processed");

endmodule

`default_nettype wire
